// File: rtl/bsc_pkg.sv
`default_nettype none
package bsc_pkg;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int DIV_STAGES = 64;

  // register indexes
  localparam logic [1:0] REG_CAL_TEMP    = 2'd0;
  localparam logic [1:0] REG_CAL_PRESS_A = 2'd1;
  localparam logic [1:0] REG_CAL_PRESS_B = 2'd2;
  localparam logic [1:0] REG_CAL_PRESS_C = 2'd3;

  localparam logic signed [31:0] C_FINE_OFS = 32'sd128000;
  localparam logic signed [31:0] C_TEMP_OFS = 32'sd128;
  localparam logic [20:0]        C_P_FULL   = 21'd1048576;
  localparam logic [11:0]        C_NUM_MUL  = 12'd3125;
  localparam logic signed [63:0] C_DEN_BIAS = 64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic               pressure_valid;
  } res_t;

  typedef struct packed {
    logic [47:0] press_c;
    logic [47:0] press_b;
    logic [47:0] press_a;
    logic [47:0] temp;
  } cal_t;

  // front to back: temperature result, signed numerator, signed divisor
  typedef struct packed {
    logic [31:0]        temp;
    logic [63:0]        num;
    logic signed [30:0] den;
  } q_item_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] quo;
    logic [30:0] md;
    logic        neg;
    logic        zero;
    logic [31:0] temp;
  } div_t;

  // one restoring division step: shift in the next numerator bit
  function automatic div_t div_step(input div_t s);
    div_t r;
    logic [31:0] r2;
    logic [31:0] diff;
    logic        qb;
    r    = s;
    r2   = {s.rem, s.quo[63]};
    diff = r2 - {1'b0, s.md};
    qb   = (r2 >= {1'b0, s.md});
    r.rem = qb ? diff[30:0] : r2[30:0];
    r.quo = {s.quo[62:0], qb};
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bsc_queue.sv
`default_nettype none
module bsc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire bsc_pkg::q_item_t push_item,
  output logic                  full,
  input  wire logic             pop,
  output logic                  avail,
  output bsc_pkg::q_item_t      head
);
  import bsc_pkg::*;

  q_item_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign head    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/bsc_front.sv
`default_nettype none
module bsc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire bsc_pkg::in_t     in_item,
  output logic                  busy,
  input  wire bsc_pkg::cal_t    cal,
  output logic                  push,
  output bsc_pkg::q_item_t      push_item,
  input  wire logic             q_full
);
  import bsc_pkg::*;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;
  logic [11:1]        v;
  logic               adv;

  assign t1 = cal.temp[15:0];
  assign t2 = $signed(cal.temp[31:16]);
  assign t3 = $signed(cal.temp[47:32]);
  assign p1 = cal.press_a[15:0];
  assign p2 = $signed(cal.press_a[31:16]);
  assign p3 = $signed(cal.press_a[47:32]);
  assign p4 = $signed(cal.press_b[15:0]);
  assign p5 = $signed(cal.press_b[31:16]);
  assign p6 = $signed(cal.press_b[47:32]);

  // hold the whole front when the last stage cannot drop its beat
  assign adv  = !(v[11] && q_full);
  assign busy = !adv;
  assign push = v[11] && !q_full;

  // stage registers
  logic [19:0]        rt1, rp1, rp2, rp3, rp4, rp5, rp6, rp7;
  logic signed [18:0] x1_c, dd_c;
  logic signed [34:0] m1;
  logic signed [37:0] m2;
  logic signed [41:0] m3;
  logic signed [23:0] a1;
  logic signed [31:0] fine, ad, fine_c, ad_c;
  logic signed [63:0] aa;
  logic signed [47:0] ap5_5, ap2_5, ap5_6, ap2_6, ap5_7, ap2_7;
  logic [31:0]        tp5, tp6, tp7, tp8, tp9, tp10, tp11;
  logic signed [48:0] lo6, lo3;
  logic signed [47:0] hi6, hi3;
  logic signed [63:0] x6, x3;
  logic signed [63:0] bsum, dsum;
  logic [20:0]        pp;
  logic [63:0]        nb;
  logic [47:0]        dlo, dhi;
  logic [63:0]        den64_c;
  logic signed [30:0] den10, den11;
  logic [43:0]        nlo, nhi;
  logic [63:0]        num;

  assign x1_c   = $signed({2'b00, rt1[19:3]}) - $signed({2'b00, t1, 1'b0});
  assign dd_c   = $signed({3'b000, rt1[19:4]}) - $signed({3'b000, t1});
  assign fine_c = 32'(a1) + 32'($signed(m3[41:14]));
  assign ad_c   = fine_c - C_FINE_OFS;
  assign den64_c = {dhi[31:0], 32'd0} + {16'd0, dlo};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[10:1], start};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (start) begin
        rt1 <= in_item.raw_temperature;
        rp1 <= in_item.raw_pressure;
      end
      // fine temperature
      m1  <= x1_c * t2;
      m2  <= dd_c * dd_c;
      rp2 <= rp1;
      m3  <= $signed(m2[37:12]) * t3;
      a1  <= m1[34:11];
      rp3 <= rp2;
      fine <= fine_c;
      ad   <= ad_c;
      rp4  <= rp3;
      // pressure terms
      aa    <= ad * ad;
      ap5_5 <= ad * p5;
      ap2_5 <= ad * p2;
      tp5   <= (fine <<< 2) + fine + C_TEMP_OFS;
      rp5   <= rp4;
      lo6   <= $signed({1'b0, aa[31:0]}) * p6;
      hi6   <= $signed(aa[63:32]) * p6;
      lo3   <= $signed({1'b0, aa[31:0]}) * p3;
      hi3   <= $signed(aa[63:32]) * p3;
      ap5_6 <= ap5_5;
      ap2_6 <= ap2_5;
      tp6   <= tp5;
      rp6   <= rp5;
      x6    <= (64'(hi6) <<< 32) + 64'(lo6);
      x3    <= (64'(hi3) <<< 32) + 64'(lo3);
      ap5_7 <= ap5_6;
      ap2_7 <= ap2_6;
      tp7   <= tp6;
      rp7   <= rp6;
      bsum  <= x6 + (64'(ap5_7) <<< 17) + (64'(p4) <<< 35);
      dsum  <= (x3 >>> 8) + (64'(ap2_7) <<< 12) + C_DEN_BIAS;
      pp    <= C_P_FULL - {1'b0, rp7};
      tp8   <= tp7;
      // numerator and divisor
      nb    <= {12'd0, pp, 31'd0} - $unsigned(bsum);
      dlo   <= dsum[31:0] * p1;
      dhi   <= dsum[63:32] * p1;
      tp9   <= tp8;
      den10 <= $signed(den64_c[63:33]);
      nlo   <= nb[31:0] * C_NUM_MUL;
      nhi   <= nb[63:32] * C_NUM_MUL;
      tp10  <= tp9;
      num   <= {nhi[31:0], 32'd0} + {20'd0, nlo};
      den11 <= den10;
      tp11  <= tp10;
    end
  end

  assign push_item.temp = tp11;
  assign push_item.num  = num;
  assign push_item.den  = den11;

endmodule
`default_nettype wire

// File: rtl/bsc_back.sv
`default_nettype none
module bsc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             avail,
  input  wire bsc_pkg::q_item_t head,
  output logic                  pop,
  input  wire bsc_pkg::cal_t    cal,
  output logic                  done,
  output bsc_pkg::res_t         result
);
  import bsc_pkg::*;

  logic signed [15:0] p7, p8, p9;
  assign p7 = $signed(cal.press_c[15:0]);
  assign p8 = $signed(cal.press_c[31:16]);
  assign p9 = $signed(cal.press_c[47:32]);

  // the back never stalls: take a beat whenever one waits
  assign pop = avail;

  div_t               stg [DIV_STAGES + 1];
  logic [DIV_STAGES:0] sv;
  logic [6:1]         pv;

  logic [63:0]        mn_c;
  logic signed [31:0] dext_c, md_c;

  assign mn_c   = head.num[63] ? (64'd0 - head.num) : head.num;
  assign dext_c = 32'(head.den);
  assign md_c   = head.den[30] ? -dext_c : dext_c;

  logic signed [63:0] q1, q2, q3, q4, q5;
  logic [31:0]        t1r, t2r, t3r, t4r, t5r, t6r;
  logic               z1, z2, z3, z4, z5, z6;
  logic [63:0]        ll;
  logic [31:0]        lh;
  logic signed [48:0] p8l, xl;
  logic signed [47:0] p8h, xh;
  logic [63:0]        ss;
  logic signed [63:0] p8q, bb4, bb5;
  logic signed [63:0] s_c, x_c, aterm, sum;
  logic [31:0]        pres_c;

  assign s_c    = q1 >>> 13;
  assign x_c    = (64'(xh) <<< 32) + 64'(xl);
  assign pres_c = sum[39:8] + (32'(p7) <<< 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      sv   <= '0;
      pv   <= '0;
      done <= 1'b0;
    end else begin
      sv   <= {sv[DIV_STAGES-1:0], pop};
      pv   <= {pv[5:1], sv[DIV_STAGES]};
      done <= pv[6];
    end
  end

  always_ff @(posedge clk) begin
    stg[0].rem  <= '0;
    stg[0].quo  <= mn_c;
    stg[0].md   <= md_c[30:0];
    stg[0].neg  <= head.num[63] ^ head.den[30];
    stg[0].zero <= (head.den == '0);
    stg[0].temp <= head.temp;
    for (int k = 0; k < DIV_STAGES; k++) begin
      stg[k+1] <= div_step(stg[k]);
    end
    // apply the quotient sign
    q1  <= stg[DIV_STAGES].neg ? -$signed(stg[DIV_STAGES].quo) : $signed(stg[DIV_STAGES].quo);
    z1  <= stg[DIV_STAGES].zero;
    t1r <= stg[DIV_STAGES].temp;
    ll  <= s_c[31:0] * s_c[31:0];
    lh  <= s_c[31:0] * s_c[63:32];
    p8l <= $signed({1'b0, q1[31:0]}) * p8;
    p8h <= $signed(q1[63:32]) * p8;
    q2  <= q1;
    z2  <= z1;
    t2r <= t1r;
    ss  <= ll + {lh[30:0], 33'd0};
    p8q <= (64'(p8h) <<< 32) + 64'(p8l);
    q3  <= q2;
    z3  <= z2;
    t3r <= t2r;
    xl  <= $signed({1'b0, ss[31:0]}) * p9;
    xh  <= $signed(ss[63:32]) * p9;
    bb4 <= p8q >>> 19;
    q4  <= q3;
    z4  <= z3;
    t4r <= t3r;
    aterm <= x_c >>> 25;
    bb5 <= bb4;
    q5  <= q4;
    z5  <= z4;
    t5r <= t4r;
    sum <= q5 + aterm + bb5;
    z6  <= z5;
    t6r <= t5r;
    result.temperature    <= $signed(t6r);
    result.pressure       <= z6 ? 32'd0 : pres_c;
    result.pressure_valid <= !z6;
  end

endmodule
`default_nettype wire

// File: rtl/barometric_sensor_compensation.sv
`default_nettype none
// Channel   Handshake              Payload
// input     start / busy           in_item (raw_pressure, raw_temperature)
// result    done (strobe)          result (temperature, pressure, pressure_valid)
// config    cfg_valid / cfg_ready  cfg_index, cfg_data (48 bits)
//
// One reading pair is taken per cycle while busy is low; each result is marked by a done strobe.
// The back end holds the 64-step pipelined divider.
// Reset (rst, synchronous) clears calibration and drops all beats in flight.
// busy rises only if the front-to-back queue is full; results cannot be held.
module barometric_sensor_compensation (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bsc_pkg::in_t  in_item,
  output logic               busy,
  output logic               done,
  output bsc_pkg::res_t      result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [47:0]   cfg_data
);
  import bsc_pkg::*;

  cal_t    cal;
  logic    q_push, q_full, q_pop, q_avail;
  q_item_t q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAL_TEMP:    cal.temp    <= cfg_data;
        REG_CAL_PRESS_A: cal.press_a <= cfg_data;
        REG_CAL_PRESS_B: cal.press_b <= cfg_data;
        REG_CAL_PRESS_C: cal.press_c <= cfg_data;
        default: ;
      endcase
    end
  end

  bsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .cal       (cal),
    .push      (q_push),
    .push_item (q_in),
    .q_full    (q_full)
  );

  bsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  bsc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (q_avail),
    .head   (q_head),
    .pop    (q_pop),
    .cal    (cal),
    .done   (done),
    .result (result)
  );

`ifndef SYNTH
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##84 done)
    else $error("result strobe missing at fixed latency");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.pressure_valid) |-> (result.pressure == 32'd0))
    else $error("invalid pressure not zero");
`endif

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import bsc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  in_t         in_item = '0;
  logic        busy;
  logic        done;
  res_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_CAL_TEMP;
  logic [47:0] cfg_data = '0;

  localparam int LATENCY = 84;
  localparam longint CYCLE_LIMIT = 400000;

  barometric_sensor_compensation dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // calibration copy held by the predictor
  logic [47:0] cal_words [4];
  res_t        readings_due [$];
  int          errors = 0;
  longint      cycles = 0;

  function automatic logic signed [63:0] word_signed(logic [47:0] r, int k);
    logic [15:0] w;
    w = r[16*k +: 16];
    return {{48{w[15]}}, w};
  endfunction

  function automatic logic signed [63:0] quot_trunc(logic signed [63:0] n,
                                                    logic signed [63:0] d);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic res_t compensate(in_t it);
    res_t r;
    logic signed [63:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] a, b, d, fine, p;
    adc_p = {44'd0, it.raw_pressure};
    adc_t = {44'd0, it.raw_temperature};
    t1 = {48'd0, cal_words[0][15:0]};
    t2 = word_signed(cal_words[0], 1);
    t3 = word_signed(cal_words[0], 2);
    p1 = {48'd0, cal_words[1][15:0]};
    p2 = word_signed(cal_words[1], 1);
    p3 = word_signed(cal_words[1], 2);
    p4 = word_signed(cal_words[2], 0);
    p5 = word_signed(cal_words[2], 1);
    p6 = word_signed(cal_words[2], 2);
    p7 = word_signed(cal_words[3], 0);
    p8 = word_signed(cal_words[3], 1);
    p9 = word_signed(cal_words[3], 2);
    a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    fine = a + b;
    r.temperature = 32'(fine * 5 + 128);
    a = fine - 64'sd128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      r.pressure = '0;
      r.pressure_valid = 1'b0;
    end else begin
      p = 64'sd1048576 - adc_p;
      p = quot_trunc(((p <<< 31) - b) * 64'sd3125, a);
      a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      b = (p8 * p) >>> 19;
      p = ((p + a + b) >>> 8) + (p7 <<< 4);
      r.pressure = p[31:0];
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("barometric_sensor_compensation test failed");
      $finish;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        res_t e;
        e = readings_due.pop_front();
        if (e.temperature !== result.temperature) begin
          $display("%0t: temperature expected %h actual %h", $time, e.temperature,
                   result.temperature);
          errors++;
        end
        if (e.pressure !== result.pressure) begin
          $display("%0t: pressure expected %h actual %h", $time, e.pressure,
                   result.pressure);
          errors++;
        end
        if (e.pressure_valid !== result.pressure_valid) begin
          $display("%0t: pressure_valid expected %b actual %b", $time,
                   e.pressure_valid, result.pressure_valid);
          errors++;
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n != 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drive one reading beat and hold until accepted; start stays high for the next beat
  task automatic send_reading(logic [19:0] rp, logic [19:0] rt, bit gaps);
    in_t it;
    if (gaps) idle_gap();
    it.raw_pressure = rp;
    it.raw_temperature = rt;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    readings_due.push_back(compensate(it));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_cal(logic [1:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cal_words[idx] = val;
  endtask

  task automatic load_cal(logic [47:0] ct, logic [47:0] pa, logic [47:0] pb,
                          logic [47:0] pc);
    drain();
    write_cal(REG_CAL_TEMP, ct);
    write_cal(REG_CAL_PRESS_A, pa);
    write_cal(REG_CAL_PRESS_B, pb);
    write_cal(REG_CAL_PRESS_C, pc);
    cfg_valid <= 1'b0;
  endtask

  // typical factory calibration, roughly
  localparam logic [47:0] TYP_TEMP = {16'hFC18, 16'h6A0E, 16'h6C0A};
  localparam logic [47:0] TYP_PA   = {16'h0BD0, 16'hD60F, 16'h8F5D};
  localparam logic [47:0] TYP_PB   = {16'hFFF9, 16'h00A8, 16'h1C43};
  localparam logic [47:0] TYP_PC   = {16'h1770, 16'hC4D5, 16'h000F};

  task automatic test_reset_calibration();
    // all-zero calibration: divisor zero, pressure invalid
    send_reading(20'h00000, 20'h00000, 0);
    send_reading(20'hFFFFF, 20'hFFFFF, 0);
  endtask

  task automatic test_directed();
    load_cal(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC);
    send_reading(20'h00000, 20'h00000, 0);
    send_reading(20'hFFFFF, 20'hFFFFF, 0);
    send_reading(20'h00000, 20'hFFFFF, 0);
    send_reading(20'hFFFFF, 20'h00000, 0);
    send_reading(20'h65A00, 20'h7EED0, 0);
    send_reading(20'h55555, 20'hAAAAA, 0);
    send_reading(20'hAAAAA, 20'h55555, 0);
    load_cal({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
    send_reading(20'h00000, 20'h00000, 0);
    send_reading(20'hFFFFF, 20'hFFFFF, 0);
    load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'hFFFF},
             {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_reading(20'h00000, 20'hFFFFF, 0);
    send_reading(20'hFFFFF, 20'h00000, 0);
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h0001},
             {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000});
    send_reading(20'h00000, 20'h00000, 0);
    send_reading(20'hFFFFF, 20'hFFFFF, 0);
    // P1 zero with nonzero rest: divisor zero, temperature still computed
    load_cal(TYP_TEMP, {TYP_PA[47:16], 16'h0000}, TYP_PB, TYP_PC);
    send_reading(20'h65A00, 20'h7EED0, 0);
    send_reading(20'hFFFFF, 20'h12345, 0);
  endtask

  task automatic test_random_stream(int n, bit typical);
    logic [47:0] c [4];
    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 4; k++) begin
        c[k] = 48'({$urandom, $urandom});
      end
      if (typical) begin
        c[0] = TYP_TEMP ^ 48'($urandom_range(0, 255));
        c[1] = TYP_PA ^ 48'($urandom_range(0, 255));
      end
      load_cal(c[0], c[1], c[2], c[3]);
      for (int i = 0; i < n / 8; i++) begin
        // most readings near realistic levels, the rest full range
        if (typical && $urandom_range(0, 3) != 0)
          send_reading(20'($urandom_range(200000, 700000)),
                       20'($urandom_range(400000, 600000)), ph % 2 == 0);
        else
          send_reading(20'($urandom), 20'($urandom), ph % 2 == 0);
      end
    end
  endtask

  task automatic test_pause_until_empty();
    load_cal(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC);
    for (int i = 0; i < 20; i++) send_reading(20'($urandom), 20'($urandom), 0);
    start <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_reading(20'($urandom), 20'($urandom), 1);
  endtask

  initial begin
    for (int k = 0; k < 4; k++) cal_words[k] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_calibration();
    test_directed();
    test_random_stream(1000, 1);
    test_random_stream(960, 0);
    test_pause_until_empty();
    drain();
    if (errors == 0) begin
      $display("barometric_sensor_compensation test passed");
    end else begin
      $display("barometric_sensor_compensation test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
